@@ rtl/hsk_pkg.sv @@
package hsk_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int CHILD_W  = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BSTART,
    ST_RD_TOP,
    ST_LD_TOP,
    ST_CHK,
    ST_LDL,
    ST_CMP,
    ST_NEXT,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_ERD,
    ST_EOUT,
    ST_EWAIT
  } state_t;

  typedef enum logic [2:0] {
    RD_TOP,
    RD_LEFT,
    RD_RIGHT,
    RD_ROOT,
    RD_LASTEL,
    RD_EMIT
  } rd_sel_t;

  typedef struct packed {
    logic    load_word;
    rd_sel_t rd_sel;
    logic    start_build;
    logic    ld_top;
    logic    ld_left;
    logic    cmp_step;
    logic    sift_wr;
    logic    swap_hold;
    logic    swap_fin;
    logic    dec_i;
    logic    start_extract;
    logic    out_load;
    logic    out_done;
    logic    clear_count;
  } cmd_t;

  typedef struct packed {
    logic child_gt_end;
    logic stop;
    logic i_one;
    logic i_two;
    logic cnt_one;
    logic out_last;
  } sts_t;

endpackage

@@ rtl/heap_sort_keys_core.sv @@
// Heap sorter for signed 32-bit keys. Words are taken one per cycle into a
// 64-entry store until a word with last_in set arrives; keys beyond 64 are
// dropped (a dropped word with last_in still starts the sort). The block then
// stalls its input, builds a max-heap in place and extracts it, and returns
// every held key in ascending order, last_out marking the largest. All heap
// work runs on one simple dual-port RAM with a registered read, so each
// sift-down level has separate steps for the left read, the right read and
// the compare and write, a sift-down that runs to the bottom adds one more
// check step, and each sift-down is set up by reading its top entry in the
// heap build and by swapping the root and the last entry in the extraction.
// Each emitted word is read, loaded into the output register and held there
// until out_stall is low.
module heap_sort_keys_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [hsk_pkg::KEY_W-1:0] key_in,
  input  logic                             last_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [hsk_pkg::KEY_W-1:0] key_out,
  output logic                             last_out
);
  import hsk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  hsk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_in   (last_in),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // key store and heap walk registers
  hsk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .key_in    (key_in),
    .out_valid (out_valid),
    .key_out   (key_out),
    .last_out  (last_out)
  );

endmodule

@@ rtl/hsk_ram.sv @@
module hsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hsk_dp.sv @@
module hsk_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  hsk_pkg::cmd_t                       cmd,
  output hsk_pkg::sts_t                       sts,
  input  logic signed [hsk_pkg::KEY_W-1:0]    key_in,
  output logic                                out_valid,
  output logic signed [hsk_pkg::KEY_W-1:0]    key_out,
  output logic                                last_out
);
  import hsk_pkg::*;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          i;
  logic [CNT_W-1:0]          pos;
  logic [CNT_W-1:0]          heap_end;
  logic [CHILD_W-1:0]        child;
  logic [IDX_W-1:0]          k;
  logic signed [KEY_W-1:0]   held;
  logic signed [KEY_W-1:0]   lval;
  logic signed [KEY_W-1:0]   tmp;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [KEY_W-1:0]          wdata;
  logic [IDX_W-1:0]          raddr;
  logic [KEY_W-1:0]          rdata;
  logic signed [KEY_W-1:0]   rval;

  logic                      right_ok;
  logic                      take_right;
  logic signed [KEY_W-1:0]   big;
  logic [CHILD_W-1:0]        big_idx;
  logic [IDX_W-1:0]          pos_addr;
  logic [IDX_W-1:0]          i_addr;
  logic                      store_full;

  assign rval       = $signed(rdata);
  assign pos_addr   = IDX_W'(pos - CNT_W'(1));
  assign i_addr     = IDX_W'(i - CNT_W'(1));
  assign store_full = (count == CNT_W'(MAX_KEYS));

  // larger child and the stop test of one sift-down level
  assign right_ok   = (child < {1'b0, heap_end});
  assign take_right = right_ok && (lval < rval);
  assign big        = take_right ? rval : lval;
  assign big_idx    = take_right ? (child + CHILD_W'(1)) : child;

  assign sts.child_gt_end = (child > {1'b0, heap_end});
  assign sts.stop         = (held >= big);
  assign sts.i_one        = (i == CNT_W'(1));
  assign sts.i_two        = (i == CNT_W'(2));
  assign sts.cnt_one      = (count == CNT_W'(1));
  assign sts.out_last     = (({1'b0, k} + CNT_W'(1)) == n);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:    raddr = i_addr;
      RD_LEFT:   raddr = IDX_W'(child - CHILD_W'(1));
      RD_RIGHT:  raddr = child[IDX_W-1:0];
      RD_ROOT:   raddr = '0;
      RD_LASTEL: raddr = i_addr;
      RD_EMIT:   raddr = k;
      default:   raddr = '0;
    endcase
  end

  // write port select, at most one writer per cycle
  always_comb begin
    we    = 1'b0;
    waddr = pos_addr;
    wdata = held;
    if (cmd.load_word) begin
      we    = !store_full;
      waddr = count[IDX_W-1:0];
      wdata = key_in;
    end else if (cmd.cmp_step) begin
      we    = 1'b1;
      wdata = sts.stop ? held : big;
    end else if (cmd.sift_wr) begin
      we    = 1'b1;
    end else if (cmd.swap_fin) begin
      we    = 1'b1;
      waddr = i_addr;
      wdata = tmp;
    end
  end

  hsk_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // key count, saturating at capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.load_word && !store_full) begin
      count <= count + CNT_W'(1);
    end
  end

  // heap walk registers
  always_ff @(posedge clk) begin
    if (cmd.start_build) begin
      n <= count;
      i <= count >> 1;
      k <= '0;
    end else if (cmd.start_extract) begin
      i <= n;
    end else if (cmd.dec_i) begin
      i <= i - CNT_W'(1);
    end
    if (cmd.ld_top) begin
      held     <= rval;
      pos      <= i;
      child    <= {i, 1'b0};
      heap_end <= n;
    end else if (cmd.swap_fin) begin
      held     <= rval;
      pos      <= CNT_W'(1);
      child    <= CHILD_W'(2);
      heap_end <= i - CNT_W'(1);
    end else if (cmd.cmp_step && !sts.stop) begin
      pos   <= CNT_W'(big_idx);
      child <= {big_idx[CHILD_W-2:0], 1'b0};
    end
    if (cmd.ld_left) begin
      lval <= rval;
    end
    if (cmd.swap_hold) begin
      tmp <= rval;
    end
    if (cmd.out_done) begin
      k <= k + IDX_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (cmd.out_done) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      key_out  <= rval;
      last_out <= sts.out_last;
    end
  end

endmodule

@@ rtl/hsk_ctrl.sv @@
module hsk_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          last_in,
  output logic          in_stall,
  input  logic          out_stall,
  input  hsk_pkg::sts_t sts,
  output hsk_pkg::cmd_t cmd
);
  import hsk_pkg::*;

  state_t state;
  state_t state_next;
  logic   extracting;
  logic   extracting_next;
  logic   in_acc;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      extracting <= 1'b0;
    end else begin
      state      <= state_next;
      extracting <= extracting_next;
    end
  end

  // next state
  always_comb begin
    state_next      = state;
    extracting_next = extracting;
    case (state)
      ST_LOAD: begin
        if (in_acc && last_in) begin
          state_next = ST_BSTART;
        end
      end
      ST_BSTART: begin
        extracting_next = 1'b0;
        state_next      = sts.cnt_one ? ST_ERD : ST_RD_TOP;
      end
      ST_RD_TOP: state_next = ST_LD_TOP;
      ST_LD_TOP: state_next = ST_CHK;
      ST_CHK:    state_next = sts.child_gt_end ? ST_NEXT : ST_LDL;
      ST_LDL:    state_next = ST_CMP;
      ST_CMP:    state_next = sts.stop ? ST_NEXT : ST_CHK;
      ST_NEXT: begin
        if (!extracting) begin
          if (sts.i_one) begin
            extracting_next = 1'b1;
            state_next      = ST_SW0;
          end else begin
            state_next = ST_RD_TOP;
          end
        end else begin
          state_next = sts.i_two ? ST_ERD : ST_SW0;
        end
      end
      ST_SW0: state_next = ST_SW1;
      ST_SW1: state_next = ST_SW2;
      ST_SW2: state_next = ST_CHK;
      ST_ERD:  state_next = ST_EOUT;
      ST_EOUT: state_next = ST_EWAIT;
      ST_EWAIT: begin
        if (!out_stall) begin
          state_next = sts.out_last ? ST_LOAD : ST_ERD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_TOP;
    case (state)
      ST_LOAD:   cmd.load_word   = in_acc;
      ST_BSTART: cmd.start_build = 1'b1;
      ST_RD_TOP: cmd.rd_sel      = RD_TOP;
      ST_LD_TOP: cmd.ld_top      = 1'b1;
      ST_CHK: begin
        cmd.rd_sel  = RD_LEFT;
        cmd.sift_wr = sts.child_gt_end;
      end
      ST_LDL: begin
        cmd.ld_left = 1'b1;
        cmd.rd_sel  = RD_RIGHT;
      end
      ST_CMP: cmd.cmp_step = 1'b1;
      ST_NEXT: begin
        if (!extracting) begin
          cmd.start_extract = sts.i_one;
          cmd.dec_i         = !sts.i_one;
        end else begin
          cmd.dec_i = !sts.i_two;
        end
      end
      ST_SW0: cmd.rd_sel = RD_ROOT;
      ST_SW1: begin
        cmd.swap_hold = 1'b1;
        cmd.rd_sel    = RD_LASTEL;
      end
      ST_SW2:  cmd.swap_fin = 1'b1;
      ST_ERD:  cmd.rd_sel   = RD_EMIT;
      ST_EOUT: cmd.out_load = 1'b1;
      ST_EWAIT: begin
        cmd.out_done    = !out_stall;
        cmd.clear_count = !out_stall && sts.out_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule
